>>> rtl/hrp_pkg.sv
// hrp_pkg: types, codes and text-matching helpers for the HTTP request header parser.
// Used by hrp_engine, http_request_header_parser_unit and tb_top; depends on nothing.
package hrp_pkg;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_MALFORMED = 3'd1;
   localparam logic [2:0] ST_METHOD    = 3'd2;
   localparam logic [2:0] ST_VERSION   = 3'd3;
   localparam logic [2:0] ST_EMPTY_URI = 3'd4;
   localparam logic [2:0] ST_TOO_LARGE = 3'd5;
   localparam logic [2:0] ST_CTYPE     = 3'd6;
   localparam logic [2:0] ST_BODY      = 3'd7;

   // csr indexes
   localparam logic CSR_MAX_HEADER = 1'b0;
   localparam logic CSR_MAX_BODY   = 1'b1;

   // method scan status
   localparam logic [1:0] MS_PENDING = 2'd0;
   localparam logic [1:0] MS_OK      = 2'd1;
   localparam logic [1:0] MS_BAD     = 2'd2;
   localparam logic [1:0] MS_UNKNOWN = 2'd3;

   // header value kinds
   localparam logic [1:0] VK_NONE = 2'd0;
   localparam logic [1:0] VK_CONN = 2'd1;
   localparam logic [1:0] VK_TYPE = 2'd2;
   localparam logic [1:0] VK_LEN  = 2'd3;

   localparam logic [1:0] METHOD_POST = 2'd1;

   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_COLON = 8'd58;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_DEL   = 8'd127;

   localparam logic [63:0] VER_11 = "HTTP/1.1";
   localparam logic [63:0] VER_10 = "HTTP/1.0";

   typedef enum logic [3:0] {
      PH_LEAD  = 4'b0001,
      PH_LINE  = 4'b0010,
      PH_NAME  = 4'b0100,
      PH_VALUE = 4'b1000
   } hrp_phase_type;

   typedef struct packed {
      hrp_phase_type phase;
      logic [7:0]    p1;
      logic [7:0]    p2;
      logic [63:0]   tail;
      logic          cr;
      logic [5:0]    req_pos;
      logic [2:0]    mlive;
      logic [1:0]    mstat;
      logic [2:0]    mlen;
      logic [2:0]    line_err;
      logic [5:0]    mpos;
      logic [4:0]    mflags;
      logic          colon;
      logic [1:0]    vkind;
      logic [1:0]    tok;
      logic [3:0]    bnd;
      logic [1:0]    mreg;
      logic          ver;
      logic          keep;
      logic [1:0]    kind;
      logic [2:0]    err;
   } hrp_state_type;

   localparam hrp_state_type ST_INIT = '{phase: PH_LEAD, mlive: 3'b111, mflags: 5'b00111,
                                         default: '0};

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  method_code;
      logic        version_code;
      logic        keep_alive;
      logic [1:0]  content_kind;
      logic [31:0] content_length;
      logic [15:0] header_bytes;
   } hrp_result_type;

   function automatic logic [7:0] lower_c(input logic [7:0] c);
      if (c >= 8'd65 && c <= 8'd90) return c + 8'd32;
      return c;
   endfunction

   // true when text s (length n, right aligned) has byte c at position pos
   function automatic logic str_match(input logic [279:0] s, input int n,
                                      input logic [5:0] pos, input logic [7:0] c);
      logic [279:0] sh;
      if (int'(pos) >= n) return 1'b0;
      sh = s >> ((n - 1 - int'(pos)) * 8);
      return sh[7:0] == c;
   endfunction

   function automatic logic [5:0] inc_sat(input logic [5:0] v);
      return (v == 6'd63) ? v : v + 6'd1;
   endfunction

   function automatic logic [2:0] meth_upd(input logic [2:0] f, input logic [5:0] pos,
                                           input logic [7:0] c);
      return {f[2] & str_match("HEAD", 4, pos, c), f[1] & str_match("POST", 4, pos, c),
              f[0] & str_match("GET", 3, pos, c)};
   endfunction

   function automatic logic [2:0] name_upd(input logic [2:0] f, input logic [5:0] pos,
                                           input logic [7:0] c);
      return {f[2] & str_match("content-length", 14, pos, c),
              f[1] & str_match("content-type", 12, pos, c),
              f[0] & str_match("connection", 10, pos, c)};
   endfunction

   function automatic logic [1:0] tok_upd(input logic [1:0] f, input logic [5:0] pos,
                                          input logic [7:0] c);
      return {f[1] & str_match("keep-alive", 10, pos, c), f[0] & str_match("close", 5, pos, c)};
   endfunction

   // end of a connection token: close clears, keep-alive sets
   function automatic logic tok_end(input logic keep, input logic [1:0] tok,
                                    input logic [4:0] f, input logic [5:0] pos);
      logic k;
      k = keep;
      if (tok == 2'd1 || tok == 2'd2) begin
         if (f[0] && pos == 6'd5) k = 1'b0;
         if (f[1] && pos == 6'd10) k = 1'b1;
      end
      return k;
   endfunction

endpackage

>>> rtl/hrp_engine.sv
// hrp_engine: parser state registers and the per-byte next-state and result logic.
// Depends on hrp_pkg.
module hrp_engine #(
   parameter int LENGTH_BITS       = 32,
   parameter int HEADER_COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             in_byte,
   input  logic [15:0]            max_header_length,
   input  logic [31:0]            max_body_length,
   output logic                   emit,
   output hrp_pkg::hrp_result_type result
);

   localparam int CW = (HEADER_COUNT_BITS > 16) ? HEADER_COUNT_BITS : 16;
   localparam int BW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

   hrp_pkg::hrp_state_type        st_ff, st_in;
   logic [HEADER_COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0]       acc_ff, acc_in;
   logic [LENGTH_BITS+3:0]       prod;
   logic [63:0]                  acc_w;
   logic [31:0]                  cnt_w;
   logic [7:0]                   c;
   logic [2:0]                   status;
   logic [5:0]                   len;
   logic                         bad, term, over, go, restart, post, ws;

   always_comb begin
      st_in   = st_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      emit    = 1'b0;
      status  = hrp_pkg::ST_OK;
      restart = 1'b0;
      go      = 1'b0;
      post    = 1'b0;
      ws      = 1'b0;
      len     = '0;
      prod    = '0;
      c       = hrp_pkg::lower_c(in_byte);
      if (cnt_ff != '1) cnt_in = cnt_ff + 1'b1;
      over = CW'(cnt_in) >= CW'(max_header_length);
      bad  = (in_byte < hrp_pkg::CH_SPACE && in_byte != hrp_pkg::CH_CR &&
              in_byte != hrp_pkg::CH_LF) || in_byte == hrp_pkg::CH_DEL;
      term = in_byte == hrp_pkg::CH_LF && (st_ff.p1 == hrp_pkg::CH_LF ||
             (st_ff.p1 == hrp_pkg::CH_CR && st_ff.p2 == hrp_pkg::CH_LF));

      if (bad) begin
         emit    = 1'b1;
         status  = over ? hrp_pkg::ST_TOO_LARGE : hrp_pkg::ST_MALFORMED;
         restart = 1'b1;
      end else begin
         st_in.p2 = st_ff.p1;
         st_in.p1 = in_byte;
         if (st_ff.phase == hrp_pkg::PH_LEAD) begin
            if (term) begin
               emit    = 1'b1;
               status  = hrp_pkg::ST_MALFORMED;
               restart = 1'b1;
            end else if (in_byte == hrp_pkg::CH_SPACE || in_byte == hrp_pkg::CH_CR ||
                         in_byte == hrp_pkg::CH_LF) begin
               if (over) begin
                  emit    = 1'b1;
                  status  = hrp_pkg::ST_TOO_LARGE;
                  restart = 1'b1;
               end
            end else begin
               st_in.phase = hrp_pkg::PH_LINE;
               go = 1'b1;
            end
         end else begin
            go = 1'b1;
         end

         if (go) begin
            // method scan over the first bytes of the request line
            if (st_in.mstat == hrp_pkg::MS_PENDING) begin
               if (st_in.req_pos >= 6'd5) begin
                  st_in.mstat = hrp_pkg::MS_BAD;
               end else if (in_byte == hrp_pkg::CH_SPACE) begin
                  st_in.mstat = (st_in.req_pos == 6'd0) ? hrp_pkg::MS_BAD : hrp_pkg::MS_UNKNOWN;
                  if (st_in.mlive[0] && st_in.req_pos == 6'd3) begin
                     st_in.mreg = 2'd0; st_in.mstat = hrp_pkg::MS_OK; st_in.mlen = 3'd3;
                  end
                  if (st_in.mlive[1] && st_in.req_pos == 6'd4) begin
                     st_in.mreg = 2'd1; st_in.mstat = hrp_pkg::MS_OK; st_in.mlen = 3'd4;
                  end
                  if (st_in.mlive[2] && st_in.req_pos == 6'd4) begin
                     st_in.mreg = 2'd2; st_in.mstat = hrp_pkg::MS_OK; st_in.mlen = 3'd4;
                  end
               end else begin
                  st_in.mlive = hrp_pkg::meth_upd(st_in.mlive, st_in.req_pos, in_byte);
               end
            end

            if (st_in.phase == hrp_pkg::PH_LINE) begin
               if (in_byte == hrp_pkg::CH_LF) begin
                  len = st_in.req_pos - {5'd0, st_in.cr};
                  if (len < 6'd8) begin
                     st_in.line_err = hrp_pkg::ST_VERSION;
                  end else if (st_in.tail == hrp_pkg::VER_11) begin
                     st_in.ver = 1'b1; st_in.keep = 1'b1;
                  end else if (st_in.tail == hrp_pkg::VER_10) begin
                     st_in.ver = 1'b0; st_in.keep = 1'b0;
                  end else begin
                     st_in.line_err = hrp_pkg::ST_VERSION;
                  end
                  if (st_in.line_err == hrp_pkg::ST_OK &&
                      {1'b0, len} <= {4'd0, st_in.mlen} + 7'd10)
                     st_in.line_err = hrp_pkg::ST_EMPTY_URI;
                  st_in.phase = hrp_pkg::PH_NAME; st_in.mpos = '0; st_in.mflags = 5'b00111;
                  st_in.colon = 1'b0; st_in.vkind = hrp_pkg::VK_NONE;
               end else begin
                  if (st_in.cr) st_in.tail = {st_in.tail[55:0], hrp_pkg::CH_CR};
                  st_in.cr = in_byte == hrp_pkg::CH_CR;
                  if (!st_in.cr) st_in.tail = {st_in.tail[55:0], in_byte};
               end
            end else if (in_byte == hrp_pkg::CH_LF) begin
               if (st_in.phase == hrp_pkg::PH_VALUE) begin
                  case (st_in.vkind)
                     hrp_pkg::VK_CONN:
                        st_in.keep = hrp_pkg::tok_end(st_in.keep, st_in.tok, st_in.mflags,
                                                      st_in.mpos);
                     hrp_pkg::VK_TYPE: begin
                        if (st_in.mflags[2]) begin
                           st_in.kind = 2'd1;
                        end else if (st_in.mflags[3]) begin
                           st_in.kind = 2'd2;
                           if (!st_in.mflags[4] && st_in.err == hrp_pkg::ST_OK)
                              st_in.err = hrp_pkg::ST_CTYPE;
                        end else if (st_in.err == hrp_pkg::ST_OK) begin
                           st_in.err = hrp_pkg::ST_CTYPE;
                        end
                     end
                     hrp_pkg::VK_LEN:
                        if (BW'(acc_in) > BW'(max_body_length) && st_in.err == hrp_pkg::ST_OK)
                           st_in.err = hrp_pkg::ST_BODY;
                     default: ;
                  endcase
               end
               st_in.phase = hrp_pkg::PH_NAME; st_in.mpos = '0; st_in.mflags = 5'b00111;
               st_in.colon = 1'b0; st_in.vkind = hrp_pkg::VK_NONE;
            end else if (st_in.phase == hrp_pkg::PH_NAME) begin
               if (st_in.colon) begin
                  st_in.colon = 1'b0;
                  if (in_byte == hrp_pkg::CH_SPACE) begin
                     post = st_in.mstat == hrp_pkg::MS_OK && st_in.mreg == hrp_pkg::METHOD_POST;
                     st_in.vkind = hrp_pkg::VK_NONE;
                     if (st_in.mflags[0] && st_in.mpos == 6'd10)
                        st_in.vkind = hrp_pkg::VK_CONN;
                     if (st_in.mflags[1] && st_in.mpos == 6'd12)
                        st_in.vkind = post ? hrp_pkg::VK_TYPE : hrp_pkg::VK_NONE;
                     if (st_in.mflags[2] && st_in.mpos == 6'd14)
                        st_in.vkind = post ? hrp_pkg::VK_LEN : hrp_pkg::VK_NONE;
                     if (st_in.vkind == hrp_pkg::VK_LEN) acc_in = '0;
                     st_in.phase  = hrp_pkg::PH_VALUE;
                     st_in.mpos   = '0;
                     st_in.mflags = (st_in.vkind == hrp_pkg::VK_LEN) ? 5'b00000 : 5'b00011;
                     st_in.tok    = '0;
                     st_in.bnd    = '0;
                  end else begin
                     st_in.mflags[2:0] = hrp_pkg::name_upd(st_in.mflags[2:0], st_in.mpos,
                                                           hrp_pkg::CH_COLON);
                     st_in.mpos = hrp_pkg::inc_sat(st_in.mpos);
                  end
               end
               if (st_in.phase == hrp_pkg::PH_NAME) begin
                  if (in_byte == hrp_pkg::CH_COLON) begin
                     st_in.colon = 1'b1;
                  end else begin
                     st_in.mflags[2:0] = hrp_pkg::name_upd(st_in.mflags[2:0], st_in.mpos, c);
                     st_in.mpos = hrp_pkg::inc_sat(st_in.mpos);
                  end
               end
            end else begin
               case (st_in.vkind)
                  hrp_pkg::VK_CONN: begin
                     ws = c == hrp_pkg::CH_SPACE || c == hrp_pkg::CH_CR;
                     if (c == hrp_pkg::CH_COMMA) begin
                        st_in.keep = hrp_pkg::tok_end(st_in.keep, st_in.tok, st_in.mflags,
                                                      st_in.mpos);
                        st_in.tok = '0; st_in.mpos = '0; st_in.mflags = 5'b00011;
                     end else begin
                        if (st_in.tok == 2'd0 && !ws) st_in.tok = 2'd1;
                        else if (st_in.tok == 2'd1 && ws) st_in.tok = 2'd2;
                        else if (st_in.tok == 2'd2 && !ws) st_in.tok = 2'd3;
                        if (st_in.tok == 2'd1 && !ws) begin
                           st_in.mflags[1:0] = hrp_pkg::tok_upd(st_in.mflags[1:0], st_in.mpos, c);
                           st_in.mpos = hrp_pkg::inc_sat(st_in.mpos);
                        end
                     end
                  end
                  hrp_pkg::VK_TYPE: begin
                     if (st_in.mflags[0]) begin
                        if (hrp_pkg::str_match("application/x-www-form-urlencoded", 33,
                                               st_in.mpos, c)) begin
                           if (st_in.mpos == 6'd32) st_in.mflags[2] = 1'b1;
                        end else begin
                           st_in.mflags[0] = 1'b0;
                        end
                     end
                     if (st_in.mflags[1]) begin
                        if (hrp_pkg::str_match("multipart/form-data", 19, st_in.mpos, c)) begin
                           if (st_in.mpos == 6'd18) st_in.mflags[3] = 1'b1;
                        end else begin
                           st_in.mflags[1] = 1'b0;
                        end
                     end
                     if (st_in.mpos >= 6'd19 && !st_in.mflags[4]) begin
                        if (hrp_pkg::str_match("boundary=", 9, {2'd0, st_in.bnd}, c)) begin
                           st_in.bnd = st_in.bnd + 4'd1;
                           if (st_in.bnd >= 4'd9) st_in.mflags[4] = 1'b1;
                        end else begin
                           st_in.bnd = (c == 8'd98) ? 4'd1 : 4'd0;
                        end
                     end
                     st_in.mpos = hrp_pkg::inc_sat(st_in.mpos);
                  end
                  hrp_pkg::VK_LEN: begin
                     if (!st_in.mflags[0]) begin
                        if (c >= 8'd48 && c <= 8'd57) begin
                           prod = (LENGTH_BITS+4)'({acc_in, 3'b000}) +
                                  (LENGTH_BITS+4)'({acc_in, 1'b0}) + (LENGTH_BITS+4)'(c[3:0]);
                           acc_in = (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1 :
                                    prod[LENGTH_BITS-1:0];
                        end else begin
                           st_in.mflags[0] = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end

            st_in.req_pos = hrp_pkg::inc_sat(st_in.req_pos);

            if (term) begin
               emit    = 1'b1;
               restart = 1'b1;
               if (st_in.mstat != hrp_pkg::MS_OK)
                  status = (st_in.mstat == hrp_pkg::MS_UNKNOWN) ? hrp_pkg::ST_METHOD :
                           hrp_pkg::ST_MALFORMED;
               else if (st_in.line_err != hrp_pkg::ST_OK)
                  status = st_in.line_err;
               else
                  status = st_in.err;
            end else if (over) begin
               emit    = 1'b1;
               status  = hrp_pkg::ST_TOO_LARGE;
               restart = 1'b1;
            end
         end
      end

      acc_w = 64'(acc_in);
      cnt_w = 32'(cnt_in);
      result.status         = status;
      result.method_code    = (status == hrp_pkg::ST_OK) ? st_in.mreg : 2'd0;
      result.version_code   = (status == hrp_pkg::ST_OK) ? st_in.ver : 1'b0;
      result.keep_alive     = (status == hrp_pkg::ST_OK) ? st_in.keep : 1'b0;
      result.content_kind   = (status == hrp_pkg::ST_OK) ? st_in.kind : 2'd0;
      result.content_length = (status == hrp_pkg::ST_OK) ? acc_w[31:0] : 32'd0;
      result.header_bytes   = cnt_w[15:0];

      if (restart) begin
         st_in  = hrp_pkg::ST_INIT;
         cnt_in = '0;
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= hrp_pkg::ST_INIT;
         cnt_ff <= '0;
         acc_ff <= '0;
      end else if (fire) begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         acc_ff <= acc_in;
      end
   end

   // no ok result leaves while the parser still waits for the request line
   assert property (@(posedge clock) disable iff (reset)
      fire && emit && result.status == hrp_pkg::ST_OK |-> st_ff.phase != hrp_pkg::PH_LEAD)
      else $error("ok result from leading whitespace");
   // after a result the next byte starts from a clean parser
   assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> cnt_ff == '0 && st_ff.phase == hrp_pkg::PH_LEAD)
      else $error("parser not restarted after result");
   // content type decode only in value phase of a POST
   assert property (@(posedge clock) disable iff (reset)
      st_ff.vkind == hrp_pkg::VK_TYPE |-> st_ff.mreg == hrp_pkg::METHOD_POST)
      else $error("content type decoded outside POST");

endmodule

>>> rtl/http_request_header_parser_unit.sv
// http_request_header_parser_unit: top level; input register, parser engine, result register
// and csr. Depends on hrp_pkg and hrp_engine.
//
//   channel  | dir | payload
//   req_*    | in  | tdata[7:0] in_byte
//   rsp_*    | out | tdata status, method_code, version_code, keep_alive, content_kind,
//            |     |       content_length, header_bytes
//   csr_*    | in  | index 0 max_header_length, 1 max_body_length
//
// One request byte per cycle unless a held result stalls the input; each byte is held in the input
// register and its result, if any, is loaded into the result register when the engine takes it.
// Synchronous reset clears the parser state and loads csr defaults 8192 and 1048576.
// A result held on rsp_* stalls the input register, and so req_tready, until it is taken.
module http_request_header_parser_unit #(
   parameter int LENGTH_BITS       = 32,
   parameter int HEADER_COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [2:0] status, [4:3] method_code, [5] version_code,
                                    // [6] keep_alive, [8:7] content_kind,
                                    // [40:9] content_length, [56:41] header_bytes
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    rsp_valid_ff;
   hrp_pkg::hrp_result_type rsp_data_ff;
   logic [15:0]             max_hdr_ff;
   logic [31:0]             max_body_ff;
   logic                    fire, emit;
   hrp_pkg::hrp_result_type result;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff.header_bytes, rsp_data_ff.content_length,
                        rsp_data_ff.content_kind, rsp_data_ff.keep_alive,
                        rsp_data_ff.version_code, rsp_data_ff.method_code, rsp_data_ff.status};

   hrp_engine #(
      .LENGTH_BITS       (LENGTH_BITS),
      .HEADER_COUNT_BITS (HEADER_COUNT_BITS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .in_byte           (in_byte_ff),
      .max_header_length (max_hdr_ff),
      .max_body_length   (max_body_ff),
      .emit              (emit),
      .result            (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_hdr_ff   <= 16'd8192;
         max_body_ff  <= 32'd1048576;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (fire && emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_wr_en) begin
            case (csr_index)
               hrp_pkg::CSR_MAX_HEADER: max_hdr_ff <= csr_wdata[15:0];
               hrp_pkg::CSR_MAX_BODY:   max_body_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) in_byte_ff <= req_tdata;
      if (fire && emit) rsp_data_ff <= result;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data_ff.status != hrp_pkg::ST_OK |->
      rsp_data_ff.content_length == 32'd0 && rsp_data_ff.method_code == 2'd0)
      else $error("error result carries decoded fields");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_data_ff.header_bytes != 16'd0)
      else $error("result with zero byte count");
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while both stages are blocked");

endmodule

>>> test/tb_top.sv
// tb_top: self-checking bench for http_request_header_parser_unit.
// Streams request bytes in, predicts each header result in the bench, and compares it with the
// rsp channel. Depends on hrp_pkg and the unit.
module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = hrp_pkg::CSR_MAX_HEADER;
   logic [31:0] csr_wdata = '0;

   http_request_header_parser_unit i_dut (.*);

   initial forever #2 clock = ~clock;

   // header results still to come
   hrp_pkg::hrp_result_type header_q[$];
   logic [7:0]     text_q[$];
   int             errs = 0;
   int             cycles = 0;
   int             results_seen = 0;
   bit             idle_on = 1'b1;
   bit             hold_off = 1'b0;

   // predictor state
   logic [15:0] hdr_lim;
   logic [31:0] body_lim;
   hrp_pkg::hrp_phase_type ph;
   logic [15:0] cnt;
   logic [63:0] hist, tail;
   bit          crp, colp;
   int          rpos, mlen, mpos, tstage, bpos;
   logic [2:0]  mlive, lerr, ecode;
   logic [1:0]  mstat, vkind, mreg, kind;
   logic [4:0]  mflags;
   logic        vreg, kreg;
   logic [63:0] lacc;

   string verbs[3]     = '{"GET", "POST", "HEAD"};
   string hdr_names[3] = '{"connection", "content-type", "content-length"};
   string conn_toks[2] = '{"close", "keep-alive"};
   string ctypes[2]    = '{"application/x-www-form-urlencoded", "multipart/form-data"};
   string bnd_txt      = "boundary=";

   function automatic bit txt_at(string s, int pos, logic [7:0] c);
      return pos < s.len() && s[pos] == c;
   endfunction

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic void clear_parse();
      ph = hrp_pkg::PH_LEAD; cnt = '0; hist = '0; tail = '0; crp = 0; rpos = 0;
      mlive = 3'b111; mstat = hrp_pkg::MS_PENDING; mlen = 0; lerr = hrp_pkg::ST_OK; mpos = 0;
      mflags = 5'b00111; colp = 0; vkind = hrp_pkg::VK_NONE; tstage = 0; bpos = 0;
      lacc = '0; mreg = '0; vreg = 1'b0; kreg = 1'b0; kind = '0; ecode = hrp_pkg::ST_OK;
   endfunction

   function automatic hrp_pkg::hrp_result_type make_result(logic [2:0] st);
      hrp_pkg::hrp_result_type r;
      bit ok;
      ok = (st == hrp_pkg::ST_OK);
      r.status = st;
      r.method_code = ok ? mreg : 2'd0;
      r.version_code = ok ? vreg : 1'b0;
      r.keep_alive = ok ? kreg : 1'b0;
      r.content_kind = ok ? kind : 2'd0;
      r.content_length = ok ? lacc[31:0] : 32'd0;
      r.header_bytes = cnt;
      return r;
   endfunction

   function automatic void note_err(logic [2:0] e);
      if (ecode == hrp_pkg::ST_OK) ecode = e;
   endfunction

   function automatic void method_scan(logic [7:0] b);
      if (mstat != hrp_pkg::MS_PENDING) return;
      if (rpos >= 5) begin
         mstat = hrp_pkg::MS_BAD;
         return;
      end
      if (b == hrp_pkg::CH_SPACE) begin
         mstat = (rpos == 0) ? hrp_pkg::MS_BAD : hrp_pkg::MS_UNKNOWN;
         for (int i = 0; i < 3 && rpos != 0; i++)
            if (mlive[i] && verbs[i].len() == rpos) begin
               mreg = 2'(i); mstat = hrp_pkg::MS_OK; mlen = rpos;
            end
         return;
      end
      for (int i = 0; i < 3; i++)
         if (mlive[i] && !txt_at(verbs[i], rpos, b)) mlive[i] = 1'b0;
   endfunction

   function automatic void start_line();
      ph = hrp_pkg::PH_NAME; mpos = 0; mflags = 5'b00111; colp = 0; vkind = hrp_pkg::VK_NONE;
   endfunction

   function automatic void request_line_done();
      int len;
      len = rpos - (crp ? 1 : 0);
      if (len < 8) lerr = hrp_pkg::ST_VERSION;
      else if (tail == hrp_pkg::VER_11) begin
         vreg = 1'b1; kreg = 1'b1;
      end else if (tail == hrp_pkg::VER_10) begin
         vreg = 1'b0; kreg = 1'b0;
      end else lerr = hrp_pkg::ST_VERSION;
      if (lerr == hrp_pkg::ST_OK && len <= mlen + 10) lerr = hrp_pkg::ST_EMPTY_URI;
      start_line();
   endfunction

   function automatic void token_done();
      if (tstage == 1 || tstage == 2)
         for (int i = 0; i < 2; i++)
            if (mflags[i] && conn_toks[i].len() == mpos) kreg = 1'(i);
   endfunction

   function automatic void header_line_done();
      if (ph == hrp_pkg::PH_VALUE) begin
         if (vkind == hrp_pkg::VK_CONN) token_done();
         else if (vkind == hrp_pkg::VK_TYPE) begin
            if (mflags[2]) kind = 2'd1;
            else if (mflags[3]) begin
               kind = 2'd2;
               if (!mflags[4]) note_err(hrp_pkg::ST_CTYPE);
            end else note_err(hrp_pkg::ST_CTYPE);
         end else if (vkind == hrp_pkg::VK_LEN) begin
            if (lacc > {32'd0, body_lim}) note_err(hrp_pkg::ST_BODY);
         end
      end
      start_line();
   endfunction

   function automatic void name_char(logic [7:0] b);
      for (int i = 0; i < 3; i++)
         if (mflags[i] && !txt_at(hdr_names[i], mpos, to_lower(b))) mflags[i] = 1'b0;
      if (mpos < 63) mpos++;
   endfunction

   function automatic void value_begin();
      bit post;
      int hit;
      post = (mstat == hrp_pkg::MS_OK && mreg == hrp_pkg::METHOD_POST);
      hit = 3;
      for (int i = 0; i < 3; i++)
         if (mflags[i] && hdr_names[i].len() == mpos) hit = i;
      vkind = hrp_pkg::VK_NONE;
      if (hit == 0) vkind = hrp_pkg::VK_CONN;
      else if (hit == 1 && post) vkind = hrp_pkg::VK_TYPE;
      else if (hit == 2 && post) begin
         vkind = hrp_pkg::VK_LEN; lacc = '0;
      end
      ph = hrp_pkg::PH_VALUE; mpos = 0;
      mflags = (vkind == hrp_pkg::VK_LEN) ? 5'd0 : 5'd3;
      tstage = 0; bpos = 0;
   endfunction

   function automatic void value_char(logic [7:0] b);
      logic [7:0] c;
      bit ws;
      logic [63:0] d;
      c = to_lower(b);
      if (vkind == hrp_pkg::VK_CONN) begin
         ws = (c == hrp_pkg::CH_SPACE || c == hrp_pkg::CH_CR);
         if (c == hrp_pkg::CH_COMMA) begin
            token_done(); tstage = 0; mpos = 0; mflags = 5'd3;
            return;
         end
         if (tstage == 0 && !ws) tstage = 1;
         else if (tstage == 1 && ws) tstage = 2;
         else if (tstage == 2 && !ws) tstage = 3;
         if (tstage == 1 && !ws) begin
            for (int i = 0; i < 2; i++)
               if (mflags[i] && !txt_at(conn_toks[i], mpos, c)) mflags[i] = 1'b0;
            if (mpos < 63) mpos++;
         end
      end else if (vkind == hrp_pkg::VK_TYPE) begin
         for (int i = 0; i < 2; i++)
            if (mflags[i]) begin
               if (txt_at(ctypes[i], mpos, c)) begin
                  if (mpos + 1 == ctypes[i].len()) mflags[2 + i] = 1'b1;
               end else mflags[i] = 1'b0;
            end
         if (mpos >= 19 && !mflags[4]) begin
            if (c == bnd_txt[bpos]) begin
               bpos++;
               if (bpos >= 9) mflags[4] = 1'b1;
            end else bpos = (c == "b") ? 1 : 0;
         end
         if (mpos < 63) mpos++;
      end else if (vkind == hrp_pkg::VK_LEN) begin
         if (!mflags[0]) begin
            if (c >= "0" && c <= "9") begin
               d = {60'd0, c[3:0]};
               if (lacc > (64'hFFFF_FFFF - d) / 64'd10) lacc = 64'hFFFF_FFFF;
               else lacc = lacc * 64'd10 + d;
            end else mflags[0] = 1'b1;
         end
      end
   endfunction

   function automatic void request_byte(logic [7:0] b);
      method_scan(b);
      if (ph == hrp_pkg::PH_LINE) begin
         if (b == hrp_pkg::CH_LF) request_line_done();
         else begin
            if (crp) tail = {tail[55:0], hrp_pkg::CH_CR};
            crp = (b == hrp_pkg::CH_CR);
            if (!crp) tail = {tail[55:0], b};
         end
      end else if (b == hrp_pkg::CH_LF) header_line_done();
      else if (ph == hrp_pkg::PH_NAME) begin
         if (colp) begin
            colp = 0;
            if (b == hrp_pkg::CH_SPACE) value_begin();
            else name_char(hrp_pkg::CH_COLON);
         end
         if (ph == hrp_pkg::PH_NAME) begin
            if (b == hrp_pkg::CH_COLON) colp = 1;
            else name_char(b);
         end
      end else value_char(b);
      if (rpos < 63) rpos++;
   endfunction

   // returns 1 when the byte completes a header result
   function automatic bit parse_byte(logic [7:0] b, output hrp_pkg::hrp_result_type r);
      bit term;
      logic [2:0] st;
      if (cnt != 16'hFFFF) cnt++;
      if ((b < 8'd32 && b != hrp_pkg::CH_CR && b != hrp_pkg::CH_LF) || b == hrp_pkg::CH_DEL)
      begin
         r = make_result(cnt >= hdr_lim ? hrp_pkg::ST_TOO_LARGE : hrp_pkg::ST_MALFORMED);
         clear_parse();
         return 1;
      end
      term = (b == hrp_pkg::CH_LF) && (hist[7:0] == hrp_pkg::CH_LF ||
             (hist[7:0] == hrp_pkg::CH_CR && hist[15:8] == hrp_pkg::CH_LF));
      hist = {hist[55:0], b};
      if (ph == hrp_pkg::PH_LEAD) begin
         if (term) begin
            r = make_result(hrp_pkg::ST_MALFORMED);
            clear_parse();
            return 1;
         end
         if (b == hrp_pkg::CH_SPACE || b == hrp_pkg::CH_CR || b == hrp_pkg::CH_LF) begin
            if (cnt >= hdr_lim) begin
               r = make_result(hrp_pkg::ST_TOO_LARGE);
               clear_parse();
               return 1;
            end
            return 0;
         end
         ph = hrp_pkg::PH_LINE;
      end
      request_byte(b);
      if (term) begin
         if (mstat != hrp_pkg::MS_OK)
            st = (mstat == hrp_pkg::MS_UNKNOWN) ? hrp_pkg::ST_METHOD : hrp_pkg::ST_MALFORMED;
         else if (lerr != hrp_pkg::ST_OK) st = lerr;
         else st = ecode;
         r = make_result(st);
         clear_parse();
         return 1;
      end
      if (cnt >= hdr_lim) begin
         r = make_result(hrp_pkg::ST_TOO_LARGE);
         clear_parse();
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("** http_request_header_parser_unit: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      hrp_pkg::hrp_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{status: rsp_tdata[2:0], method_code: rsp_tdata[4:3],
                 version_code: rsp_tdata[5], keep_alive: rsp_tdata[6],
                 content_kind: rsp_tdata[8:7], content_length: rsp_tdata[40:9],
                 header_bytes: rsp_tdata[56:41]};
         results_seen++;
         if (header_q.size() == 0) begin
            errs++;
            $display("%0t: unexpected result %h", $time, rsp_tdata);
         end else begin
            want = header_q.pop_front();
            if (got.status != want.status || got.method_code != want.method_code ||
                got.version_code != want.version_code || got.keep_alive != want.keep_alive ||
                got.content_kind != want.content_kind ||
                got.content_length != want.content_length ||
                got.header_bytes != want.header_bytes) begin
               errs++;
               $display("%0t: expected st=%0d m=%0d v=%0d k=%0d ct=%0d len=%0d n=%0d", $time,
                        want.status, want.method_code, want.version_code, want.keep_alive,
                        want.content_kind, want.content_length, want.header_bytes);
               $display("%0t: actual   st=%0d m=%0d v=%0d k=%0d ct=%0d len=%0d n=%0d", $time,
                        got.status, got.method_code, got.version_code, got.keep_alive,
                        got.content_kind, got.content_length, got.header_bytes);
            end
         end
      end
   end

   // response side ready
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end else if (idle_on && $urandom_range(3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else rsp_tready <= 1'b1;
      end
   end

   task automatic send_byte(logic [7:0] b);
      hrp_pkg::hrp_result_type r;
      if (idle_on && $urandom_range(4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (parse_byte(b, r)) header_q.push_back(r);
   endtask

   function automatic void put_txt(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   task automatic send_text();
      while (text_q.size() > 0) send_byte(text_q.pop_front());
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (header_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == hrp_pkg::CSR_MAX_HEADER) hdr_lim = val[15:0];
      else body_lim = val;
   endtask

   function automatic void put_request();
      string crlf, m, s;
      int n;
      if ($urandom_range(1)) crlf = "\r\n";
      else crlf = "\n";
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(1)) put_txt(" ");
         else put_txt("\r\n");
      end
      case ($urandom_range(9))
         0, 1, 2: m = "GET";
         3, 4, 5, 6: m = "POST";
         7: m = "HEAD";
         8: m = "PUT";
         default: m = "DELETE";
      endcase
      put_txt(m);
      put_txt(" /");
      repeat ($urandom_range(0, 6)) text_q.push_back($urandom_range(33, 255) == 127 ?
                                                     8'd65 : 8'($urandom_range(33, 255)));
      case ($urandom_range(7))
         0: put_txt(" HTTP/1.0");
         1: put_txt(" HTTP/2.0");
         2: ;
         default: put_txt(" HTTP/1.1");
      endcase
      put_txt(crlf);
      n = $urandom_range(0, 4);
      repeat (n) begin
         case ($urandom_range(7))
            0: begin
               if ($urandom_range(1)) put_txt("Connection: ");
               else put_txt("CONNECTION: ");
               repeat ($urandom_range(1, 3)) begin
                  case ($urandom_range(3))
                     0: s = "close";
                     1: s = "Keep-Alive";
                     2: s = " keep-alive x";
                     default: s = "upgrade";
                  endcase
                  put_txt(s);
                  put_txt(",");
               end
               if ($urandom_range(1)) put_txt("close");
               else put_txt("keep-alive ");
            end
            1: put_txt("Content-Type: application/x-www-form-urlencoded");
            2: begin
               if ($urandom_range(1)) put_txt("content-type: multipart/form-data; boundary=zz");
               else put_txt("Content-Type: multipart/form-data");
            end
            3: put_txt("Content-Type: text/plain");
            4: begin
               put_txt("Content-Length: ");
               repeat ($urandom_range(0, 12)) text_q.push_back(8'($urandom_range(48, 57)));
               if ($urandom_range(1)) put_txt("x9");
            end
            5: put_txt("Host:example");
            default: put_txt("X-Any: v");
         endcase
         put_txt(crlf);
      end
      if ($urandom_range(9) == 0)
         text_q.insert($urandom_range(0, text_q.size()), 8'($urandom_range(0, 255)));
      put_txt(crlf);
   endfunction

   task automatic test_directed();
      put_txt("GET / HTTP/1.1\r\n\r\n");
      put_txt("POST /a HTTP/1.0\r\nContent-Type: multipart/form-data; boundary=q\r\n");
      put_txt("Content-Length: 99999999999\r\n\r\n");
      put_txt("HEAD /x HTTP/1.1\nConnection: close, keep-alive\nConnection: close\n\n");
      put_txt("\n\n");
      put_txt("PUT /x HTTP/1.1\n\n");
      put_txt("GET /x HTTP/2.0\n\n");
      put_txt("GET  HTTP/1.1\n\n");
      put_txt("GETTT / HTTP/1.1\n\n");
      put_txt("GET /");
      text_q.push_back(8'hFF);
      text_q.push_back(8'h80);
      text_q.push_back(8'h00);
      put_txt("GET /");
      text_q.push_back(hrp_pkg::CH_DEL);
      put_txt("POST /u HTTP/1.1\nContent-Length: 12\nContent-Type: text/x\n\n");
      send_text();
   endtask

   task automatic test_limits();
      write_csr(hrp_pkg::CSR_MAX_HEADER, 32'd1);
      put_txt(" G\n");
      text_q.push_back(8'h01);
      send_text();
      write_csr(hrp_pkg::CSR_MAX_HEADER, 32'd20);
      put_txt("GET /abcdefgh HTTP/1.1\n\n");
      send_text();
      write_csr(hrp_pkg::CSR_MAX_HEADER, 32'd65535);
      write_csr(hrp_pkg::CSR_MAX_BODY, 32'd0);
      put_txt("POST /a HTTP/1.1\nContent-Length: 0\n\nPOST /a HTTP/1.1\nContent-Length: 1\n\n");
      send_text();
      write_csr(hrp_pkg::CSR_MAX_BODY, 32'hFFFF_FFFF);
      put_txt("POST /a HTTP/1.1\nContent-Length: 4294967295\n\n");
      put_txt("POST /a HTTP/1.1\nContent-Length: 4294967296\n\n");
      send_text();
      write_csr(hrp_pkg::CSR_MAX_BODY, 32'd1000);
   endtask

   task automatic test_random(int nbytes, int nres);
      int sent;
      sent = 0;
      while (sent < nbytes || results_seen + header_q.size() < nres) begin
         if ($urandom_range(15) == 0)
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
         else put_request();
         sent += text_q.size();
         send_text();
      end
   endtask

   task automatic test_backpressure();
      drain();
      hold_off = 1'b1;
      repeat (4) put_request();
      send_text();
   endtask

   initial begin
      clear_parse();
      hdr_lim = 16'd8192;
      body_lim = 32'd1048576;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limits();
      test_random(200, 0);
      test_backpressure();
      idle_on = 1'b0;
      test_random(150, 0);
      drain();
      repeat (20) @(posedge clock);
      if (errs == 0) $display("** http_request_header_parser_unit: PASSED **");
      else $display("** http_request_header_parser_unit: FAILED **");
      $finish;
   end
endmodule

>>> http_request_header_parser_unit.f
rtl/hrp_pkg.sv
rtl/hrp_engine.sv
rtl/http_request_header_parser_unit.sv
test/tb_top.sv
